// ----- design/assert_macros.svh -----
// assertion macros shared by the entropy coder modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPL(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- design/jhe_pkg.sv -----
// constants and types of the jpeg entropy coder
package jhe_pkg;
  localparam int COEFFS_PER_BLOCK = 64;
  localparam int AC_TABLE_ENTRIES = 256;
  localparam int DC_TABLE_ENTRIES = 12;
  localparam int TABLE_CLASSES = 2;
  localparam int ENTRY_W = 21;
  localparam int DC_DEPTH = DC_TABLE_ENTRIES * TABLE_CLASSES;
  localparam int DC_AW = $clog2(DC_DEPTH);
  localparam int AC_DEPTH = AC_TABLE_ENTRIES * TABLE_CLASSES;
  localparam int AC_AW = $clog2(AC_DEPTH);

  localparam logic [1:0] OP_ENCODE = 2'd0;
  localparam logic [1:0] OP_LOAD = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;
  localparam logic [1:0] OP_RESTART = 2'd3;

  localparam logic [7:0] SYM_EOB = 8'h00;
  localparam logic [7:0] SYM_ZRL = 8'hF0;
  localparam logic [7:0] BYTE_FF = 8'hFF;
  localparam logic [7:0] BYTE_STUFF = 8'h00;
  localparam logic [5:0] POS_LAST = 6'(COEFFS_PER_BLOCK - 1);
  localparam logic [5:0] RUN_MAX = 6'd63;
  localparam logic [5:0] RUN_ZRL = 6'd16;
  localparam logic [4:0] LEN_MAX = 5'd16;

  typedef struct packed {
    logic bit_valid;
    logic bit_val;
    logic end_valid;
    logic restart;
  } pk_cmd_t;

  typedef struct packed {
    logic       ready;
    logic [2:0] count;
  } pk_stat_t;
endpackage

// ----- design/jhe_ram.sv -----
// generic single write port ram with registered read
module jhe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- design/jhe_packer.sv -----
// bit packer with byte stuffing, byte budget and output register
module jhe_packer (
  input  logic              clk,
  input  logic              rst,
  input  jhe_pkg::pk_cmd_t  cmd,
  output jhe_pkg::pk_stat_t stat,
  input  logic [31:0]       out_limit,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              last,
  output logic              overflow
);
  import jhe_pkg::*;
  `include "assert_macros.svh"

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_STUFF = 2'd1;
  localparam logic [1:0] P_MARK = 2'd2;

  logic [1:0]  state, state_next;
  logic [6:0]  holdover, holdover_next;
  logic [2:0]  count, count_next;
  logic [31:0] bytes_written, bytes_written_next;
  logic        overflowed, overflowed_next;
  logic        dropped, dropped_next;
  logic        pend_v, pend_v_next;
  logic [7:0]  pend_byte, pend_byte_next;
  logic        out_valid_next, last_next, overflow_next;
  logic [7:0]  out_byte_next;
  logic        can_push, deliver_req;
  logic [7:0]  deliver_byte, byte_new;

  assign can_push = !out_valid || out_ready;
  assign byte_new = {holdover, cmd.bit_val};
  assign stat.ready = (state == P_IDLE) && can_push;
  assign stat.count = count;

  always_comb begin
    state_next = state;
    holdover_next = holdover;
    count_next = count;
    bytes_written_next = bytes_written;
    overflowed_next = overflowed;
    dropped_next = dropped;
    pend_v_next = pend_v;
    pend_byte_next = pend_byte;
    out_valid_next = out_valid && !out_ready;
    out_byte_next = out_byte;
    last_next = last;
    overflow_next = overflow;
    deliver_req = 1'b0;
    deliver_byte = BYTE_STUFF;
    case (state)
      P_IDLE: begin
        if (can_push) begin
          if (cmd.bit_valid) begin
            if (count == 3'd7) begin
              deliver_req = 1'b1;
              deliver_byte = byte_new;
              holdover_next = '0;
              count_next = '0;
              if (byte_new == BYTE_FF) begin
                state_next = P_STUFF;
              end
            end else begin
              holdover_next = {holdover[5:0], cmd.bit_val};
              count_next = count + 3'd1;
            end
          end else if (cmd.end_valid) begin
            if (pend_v) begin
              out_valid_next = 1'b1;
              out_byte_next = pend_byte;
              last_next = !dropped;
              overflow_next = 1'b0;
              pend_v_next = 1'b0;
              if (dropped) begin
                state_next = P_MARK;
              end
            end else if (dropped) begin
              out_valid_next = 1'b1;
              out_byte_next = BYTE_STUFF;
              last_next = 1'b1;
              overflow_next = 1'b1;
              dropped_next = 1'b0;
            end
          end
        end
      end
      P_STUFF: begin
        if (can_push) begin
          deliver_req = 1'b1;
          deliver_byte = BYTE_STUFF;
          state_next = P_IDLE;
        end
      end
      P_MARK: begin
        if (can_push) begin
          out_valid_next = 1'b1;
          out_byte_next = BYTE_STUFF;
          last_next = 1'b1;
          overflow_next = 1'b1;
          dropped_next = 1'b0;
          state_next = P_IDLE;
        end
      end
      default: begin
        state_next = P_IDLE;
      end
    endcase
    if (deliver_req) begin
      if (overflowed || (bytes_written >= out_limit)) begin
        overflowed_next = 1'b1;
        dropped_next = 1'b1;
      end else begin
        bytes_written_next = bytes_written + 32'd1;
        if (pend_v) begin
          out_valid_next = 1'b1;
          out_byte_next = pend_byte;
          last_next = 1'b0;
          overflow_next = 1'b0;
        end
        pend_v_next = 1'b1;
        pend_byte_next = deliver_byte;
      end
    end
    if (cmd.restart) begin
      holdover_next = '0;
      count_next = '0;
      bytes_written_next = '0;
      overflowed_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= P_IDLE;
      holdover <= '0;
      count <= '0;
      bytes_written <= '0;
      overflowed <= 1'b0;
      dropped <= 1'b0;
      pend_v <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      holdover <= holdover_next;
      count <= count_next;
      bytes_written <= bytes_written_next;
      overflowed <= overflowed_next;
      dropped <= dropped_next;
      pend_v <= pend_v_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_byte <= pend_byte_next;
    out_byte <= out_byte_next;
    last <= last_next;
    overflow <= overflow_next;
  end

  `ASSERT_IMPL(a_drop_needs_ovf, (state != P_MARK) && dropped, overflowed, "drop without overflow")
  `ASSERT_NEXT(a_restart_clears, cmd.restart, (bytes_written == 32'd0) && !overflowed, "restart")
endmodule

// ----- design/jhe_seq.sv -----
// sequencer: decodes items, reads code tables and feeds the packer one bit at a time
module jhe_seq (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                op,
  input  logic                      table_class,
  input  logic [5:0]                coeff_pos,
  input  logic signed [11:0]        coeff_value,
  input  logic                      entry_is_ac,
  input  logic [7:0]                entry_index,
  input  logic [15:0]               entry_code,
  input  logic [4:0]                entry_length,
  output logic                      dc_we,
  output logic [jhe_pkg::DC_AW-1:0] dc_waddr,
  output logic [jhe_pkg::DC_AW-1:0] dc_raddr,
  input  logic [jhe_pkg::ENTRY_W-1:0] dc_rdata,
  output logic                      ac_we,
  output logic [jhe_pkg::AC_AW-1:0] ac_waddr,
  output logic [jhe_pkg::AC_AW-1:0] ac_raddr,
  input  logic [jhe_pkg::ENTRY_W-1:0] ac_rdata,
  output logic [jhe_pkg::ENTRY_W-1:0] wdata,
  output jhe_pkg::pk_cmd_t          cmd,
  input  jhe_pkg::pk_stat_t         stat
);
  import jhe_pkg::*;
  `include "assert_macros.svh"

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC = 3'd1;
  localparam logic [2:0] S_ENT = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_EXTRA = 3'd4;
  localparam logic [2:0] S_END = 3'd5;

  logic [2:0]  state, state_next, nxt, nxt_next;
  logic        cls, cls_next, use_dc, use_dc_next, eob, eob_next;
  logic [3:0]  cat, cat_next, in_cat;
  logic [10:0] extra, extra_next, mag;
  logic [5:0]  run, run_next;
  logic [15:0] word, word_next;
  logic [4:0]  cnt, cnt_next, len_sat;
  logic [3:0]  bit_idx;
  logic [7:0]  sym;
  logic signed [11:0] v_sat, v_ext;
  logic [16:0] mask;
  logic        acc;

  assign in_ready = (state == S_IDLE);
  assign acc = in_valid && in_ready;

  assign v_sat = (coeff_value == 12'sh800) ? -12'sd2047 : coeff_value;
  assign v_ext = v_sat[11] ? (v_sat - 12'sd1) : v_sat;
  assign mag = v_sat[11] ? 11'(-v_sat) : v_sat[10:0];

  always_comb begin
    in_cat = '0;
    for (int i = 0; i < 11; i++) begin
      if (mag[i]) begin
        in_cat = 4'(i + 1);
      end
    end
  end

  assign len_sat = (entry_length > LEN_MAX) ? LEN_MAX : entry_length;
  assign mask = (17'd1 << len_sat) - 17'd1;
  assign wdata = {entry_code & mask[15:0], len_sat};
  assign dc_we = acc && (op == OP_LOAD) && !entry_is_ac &&
                 (entry_index < 8'(DC_TABLE_ENTRIES));
  assign ac_we = acc && (op == OP_LOAD) && entry_is_ac;
  assign dc_waddr = DC_AW'(table_class) * DC_AW'(DC_TABLE_ENTRIES) + entry_index[DC_AW-1:0];
  assign ac_waddr = {table_class, entry_index};

  assign dc_raddr = DC_AW'(cls) * DC_AW'(DC_TABLE_ENTRIES) + DC_AW'(cat);
  assign sym = eob ? SYM_EOB : ((run > 6'd15) ? SYM_ZRL : {run[3:0], cat});
  assign ac_raddr = {cls, sym};
  assign bit_idx = 4'(cnt - 5'd1);

  always_comb begin
    state_next = state;
    nxt_next = nxt;
    cls_next = cls;
    use_dc_next = use_dc;
    eob_next = eob;
    cat_next = cat;
    extra_next = extra;
    run_next = run;
    word_next = word;
    cnt_next = cnt;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (acc) begin
          case (op)
            OP_RESTART: begin
              cmd.restart = 1'b1;
              run_next = '0;
            end
            OP_FLUSH: begin
              if (stat.count != 3'd0) begin
                word_next = '1;
                cnt_next = 5'd8 - 5'(stat.count);
                nxt_next = S_END;
                state_next = S_SHIFT;
              end else begin
                state_next = S_END;
              end
            end
            OP_ENCODE: begin
              cls_next = table_class;
              cat_next = in_cat;
              extra_next = v_ext[10:0];
              use_dc_next = 1'b0;
              eob_next = 1'b0;
              if (coeff_pos == 6'd0) begin
                run_next = '0;
                use_dc_next = 1'b1;
                state_next = S_DEC;
              end else if (v_sat == 12'sd0) begin
                if (run < RUN_MAX) begin
                  run_next = run + 6'd1;
                end
                if (coeff_pos == POS_LAST) begin
                  run_next = '0;
                  eob_next = 1'b1;
                  state_next = S_DEC;
                end
              end else begin
                state_next = S_DEC;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_DEC: begin
        state_next = S_ENT;
        if (use_dc) begin
          nxt_next = S_EXTRA;
        end else if (eob) begin
          nxt_next = S_END;
        end else if (run > 6'd15) begin
          run_next = run - RUN_ZRL;
          nxt_next = S_DEC;
        end else begin
          run_next = '0;
          nxt_next = S_EXTRA;
        end
      end
      S_ENT: begin
        word_next = use_dc ? dc_rdata[ENTRY_W-1:5] : ac_rdata[ENTRY_W-1:5];
        cnt_next = use_dc ? dc_rdata[4:0] : ac_rdata[4:0];
        state_next = S_SHIFT;
      end
      S_SHIFT: begin
        if (cnt == 5'd0) begin
          state_next = nxt;
        end else begin
          cmd.bit_valid = 1'b1;
          cmd.bit_val = word[bit_idx];
          if (stat.ready) begin
            cnt_next = cnt - 5'd1;
          end
        end
      end
      S_EXTRA: begin
        word_next = {5'd0, extra};
        cnt_next = {1'b0, cat};
        nxt_next = S_END;
        state_next = S_SHIFT;
      end
      S_END: begin
        cmd.end_valid = 1'b1;
        if (stat.ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      run <= '0;
    end else begin
      state <= state_next;
      run <= run_next;
    end
  end

  always_ff @(posedge clk) begin
    nxt <= nxt_next;
    cls <= cls_next;
    use_dc <= use_dc_next;
    eob <= eob_next;
    cat <= cat_next;
    extra <= extra_next;
    word <= word_next;
    cnt <= cnt_next;
  end

  `ASSERT_IMPL(a_ent_after_dec, state == S_ENT, $past(state) == S_DEC, "table read order")
  `ASSERT_IMPL(a_idle_no_cmd, in_ready, !cmd.bit_valid && !cmd.end_valid, "command while idle")
endmodule

// ----- design/jpeg_huffman_entropy_coder.sv -----
// top level of the baseline jpeg huffman entropy coder
//
//  channel | signals                                 | transfer
//  input   | in_valid, in_ready, op .. entry_length  | in_valid & in_ready
//  output  | out_valid, out_ready, out_byte, last,   | out_valid & out_ready
//          | overflow                                |
//  config  | cfg_wr_en, cfg_wr_data (out_limit)      | cfg_wr_en
//
// a coded item is decoded, its table entry is read and its code and extra bits are then
// shifted into the packer one bit at a time; a run over 15 zeros first sends zero-run
// codes, an end of block sends only its code, and a zero inside a run sends no bits
// a stuffed zero holds the bit loop; a table load or restart is taken in the idle state
// reset is synchronous; table contents are undefined until loaded
// a stalled output holds the packer, which holds the sequencer
module jpeg_huffman_entropy_coder (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         op,
  input  logic               table_class,
  input  logic [5:0]         coeff_pos,
  input  logic signed [11:0] coeff_value,
  input  logic               entry_is_ac,
  input  logic [7:0]         entry_index,
  input  logic [15:0]        entry_code,
  input  logic [4:0]         entry_length,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic               last,
  output logic               overflow,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data
);
  import jhe_pkg::*;

  logic [31:0]        out_limit;
  logic               dc_we, ac_we;
  logic [DC_AW-1:0]   dc_waddr, dc_raddr;
  logic [AC_AW-1:0]   ac_waddr, ac_raddr;
  logic [ENTRY_W-1:0] dc_rdata, ac_rdata, wdata;
  pk_cmd_t            cmd;
  pk_stat_t           stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_limit <= '1;
    end else if (cfg_wr_en) begin
      out_limit <= cfg_wr_data;
    end
  end

  jhe_ram #(.WIDTH(ENTRY_W), .DEPTH(DC_DEPTH)) u_dc_ram (
    .clk(clk), .we(dc_we), .waddr(dc_waddr), .wdata(wdata),
    .raddr(dc_raddr), .rdata(dc_rdata)
  );

  jhe_ram #(.WIDTH(ENTRY_W), .DEPTH(AC_DEPTH)) u_ac_ram (
    .clk(clk), .we(ac_we), .waddr(ac_waddr), .wdata(wdata),
    .raddr(ac_raddr), .rdata(ac_rdata)
  );

  jhe_seq u_seq (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .table_class(table_class), .coeff_pos(coeff_pos),
    .coeff_value(coeff_value), .entry_is_ac(entry_is_ac),
    .entry_index(entry_index), .entry_code(entry_code),
    .entry_length(entry_length),
    .dc_we(dc_we), .dc_waddr(dc_waddr), .dc_raddr(dc_raddr), .dc_rdata(dc_rdata),
    .ac_we(ac_we), .ac_waddr(ac_waddr), .ac_raddr(ac_raddr), .ac_rdata(ac_rdata),
    .wdata(wdata), .cmd(cmd), .stat(stat)
  );

  jhe_packer u_packer (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .out_limit(out_limit),
    .out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte),
    .last(last), .overflow(overflow)
  );
endmodule

// ----- tb/sv/jpeg_huffman_entropy_coder_tb.sv -----
// self-checking testbench of the jpeg huffman entropy coder with a scoreboard class
`timescale 1ns / 1ps

module jpeg_huffman_entropy_coder_tb;
  import jhe_pkg::*;

  localparam int ITEM_RESULT_CAP = 20;
  localparam int ITEM_TARGET = 380;
  localparam int SETTLE_CYCLES = 120;

  typedef struct {
    logic [7:0] data;
    logic       fin;
    logic       ovf;
  } stream_byte_t;

  class coder_scoreboard;
    logic [ENTRY_W-1:0] dc_tab[TABLE_CLASSES][DC_TABLE_ENTRIES];
    logic [ENTRY_W-1:0] ac_tab[TABLE_CLASSES][AC_TABLE_ENTRIES];
    bit dc_loaded[TABLE_CLASSES][DC_TABLE_ENTRIES];
    bit ac_loaded[TABLE_CLASSES][AC_TABLE_ENTRIES];
    logic [7:0]  holdover;
    int unsigned held_bits;
    int unsigned zero_run;
    logic [31:0] byte_total;
    logic [31:0] byte_limit;
    bit          overflowed;
    bit          dropped;
    stream_byte_t item_bytes[$];
    stream_byte_t expected_bytes[$];

    function new();
      byte_limit = 32'hFFFF_FFFF;
      restart_stream();
    endfunction

    function void restart_stream();
      holdover = '0;
      held_bits = 0;
      zero_run = 0;
      byte_total = '0;
      overflowed = 0;
    endfunction

    function void deliver(logic [7:0] b);
      stream_byte_t sb;
      if (overflowed || byte_total >= byte_limit) begin
        overflowed = 1;
        dropped = 1;
        return;
      end
      byte_total++;
      if (item_bytes.size() < ITEM_RESULT_CAP) begin
        sb.data = b;
        sb.fin = 0;
        sb.ovf = 0;
        item_bytes.push_back(sb);
      end
    endfunction

    function void put_bits(logic [15:0] code, int unsigned len);
      if (len > LEN_MAX) len = LEN_MAX;
      for (int i = len; i > 0; i--) begin
        holdover = {holdover[6:0], code[i-1]};
        held_bits++;
        if (held_bits == 8) begin
          deliver(holdover);
          if (holdover == BYTE_FF) deliver(BYTE_STUFF);
          holdover = '0;
          held_bits = 0;
        end
      end
    endfunction

    function void put_entry(logic [ENTRY_W-1:0] e);
      put_bits(e[20:5], e[4:0]);
    endfunction

    function int signed clamp(logic signed [11:0] raw);
      int signed v;
      v = raw;
      if (v < -2047) v = -2047;
      return v;
    endfunction

    function int unsigned category(int signed v);
      int unsigned m;
      int unsigned c;
      m = (v < 0) ? -v : v;
      c = 0;
      while (m != 0) begin
        c++;
        m >>= 1;
      end
      return c;
    endfunction

    function void put_extra(int signed v, int unsigned cat);
      int unsigned bits;
      bits = (v < 0) ? v - 1 : v;
      if (cat != 0) put_bits(16'(bits & ((1 << cat) - 1)), cat);
    endfunction

    // dc and ac entries an encode would read, as is_ac*256 + index, that were never loaded
    function void missing_entries(int cls, int pos, logic signed [11:0] raw, ref int need[$]);
      int signed v;
      int unsigned cat;
      int unsigned run;
      need.delete();
      v = clamp(raw);
      cat = category(v);
      if (pos == 0) begin
        if (!dc_loaded[cls][cat]) need.push_back(cat);
      end else if (v == 0) begin
        if (pos == POS_LAST && !ac_loaded[cls][SYM_EOB]) need.push_back(256 + SYM_EOB);
      end else begin
        run = zero_run;
        if (run > 15 && !ac_loaded[cls][SYM_ZRL]) need.push_back(256 + SYM_ZRL);
        run = run % 16;
        if (!ac_loaded[cls][(run << 4) | cat]) need.push_back(256 + ((run << 4) | cat));
      end
    endfunction

    function void encode(int cls, int pos, int signed v);
      int unsigned cat;
      cat = category(v);
      if (pos == 0) begin
        zero_run = 0;
        put_entry(dc_tab[cls][cat]);
        put_extra(v, cat);
        return;
      end
      if (v == 0) begin
        if (zero_run < RUN_MAX) zero_run++;
        if (pos == POS_LAST) begin
          put_entry(ac_tab[cls][SYM_EOB]);
          zero_run = 0;
        end
        return;
      end
      while (zero_run > 15) begin
        put_entry(ac_tab[cls][SYM_ZRL]);
        zero_run -= RUN_ZRL;
      end
      put_entry(ac_tab[cls][((zero_run << 4) | cat) & 8'hFF]);
      put_extra(v, cat);
      zero_run = 0;
    endfunction

    function void note_transfer(logic [1:0] op, logic cls, logic [5:0] pos,
                                logic signed [11:0] val, logic is_ac, logic [7:0] idx,
                                logic [15:0] code, logic [4:0] len);
      stream_byte_t mk;
      int unsigned l;
      logic [15:0] c;
      item_bytes.delete();
      dropped = 0;
      if (op == OP_RESTART) begin
        restart_stream();
        return;
      end
      if (op == OP_LOAD) begin
        l = (len > LEN_MAX) ? LEN_MAX : len;
        c = code & 16'((32'd1 << l) - 1);
        if (is_ac) begin
          ac_tab[cls][idx] = {c, 5'(l)};
          ac_loaded[cls][idx] = 1;
        end else if (idx < DC_TABLE_ENTRIES) begin
          dc_tab[cls][idx] = {c, 5'(l)};
          dc_loaded[cls][idx] = 1;
        end
        return;
      end
      if (op == OP_FLUSH) begin
        if (held_bits > 0) put_bits(16'((1 << (8 - held_bits)) - 1), 8 - held_bits);
      end else begin
        encode(cls, pos, clamp(val));
      end
      if (dropped) begin
        if (item_bytes.size() >= ITEM_RESULT_CAP) void'(item_bytes.pop_back());
        mk.data = '0;
        mk.fin = 0;
        mk.ovf = 1;
        item_bytes.push_back(mk);
      end
      if (item_bytes.size() > 0) item_bytes[item_bytes.size()-1].fin = 1;
      foreach (item_bytes[i]) expected_bytes.push_back(item_bytes[i]);
    endfunction

    // empty string when the transfer matches the oldest expected byte
    function string check_byte(logic [7:0] b, logic fin, logic ovf);
      stream_byte_t e;
      if (expected_bytes.size() == 0)
        return $sformatf("unexpected output byte %02h last %0b overflow %0b", b, fin, ovf);
      e = expected_bytes.pop_front();
      if (b !== e.data || fin !== e.fin || ovf !== e.ovf)
        return $sformatf("got byte %02h last %0b overflow %0b, want %02h last %0b overflow %0b",
                         b, fin, ovf, e.data, e.fin, e.ovf);
      return "";
    endfunction
  endclass

  logic               clk = 0;
  logic               rst = 1;
  logic               in_valid = 0;
  logic               in_ready;
  logic [1:0]         op = OP_ENCODE;
  logic               table_class = 0;
  logic [5:0]         coeff_pos = '0;
  logic signed [11:0] coeff_value = '0;
  logic               entry_is_ac = 0;
  logic [7:0]         entry_index = '0;
  logic [15:0]        entry_code = '0;
  logic [4:0]         entry_length = '0;
  logic               out_valid;
  logic               out_ready = 0;
  logic [7:0]         out_byte;
  logic               last;
  logic               overflow;
  logic               cfg_wr_en = 0;
  logic [31:0]        cfg_wr_data = '0;

  coder_scoreboard stream_sb = new();
  int errors = 0;
  int items_sent = 0;
  int burst_left = 0;
  int stall_mode = 0;

  jpeg_huffman_entropy_coder dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .table_class(table_class), .coeff_pos(coeff_pos), .coeff_value(coeff_value),
    .entry_is_ac(entry_is_ac), .entry_index(entry_index), .entry_code(entry_code),
    .entry_length(entry_length),
    .out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte), .last(last),
    .overflow(overflow),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always #2 clk = ~clk;

  task automatic report(string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // receiver stall pattern changes at random times among four modes
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1;
      1: out_ready <= $urandom_range(0, 1);
      2: out_ready <= ($urandom_range(0, 9) == 0);
      default: out_ready <= ($urandom_range(0, 9) != 0);
    endcase
  end

  always @(posedge clk) begin
    string msg;
    if (!rst && out_valid && out_ready) begin
      msg = stream_sb.check_byte(out_byte, last, overflow);
      if (msg != "") report(msg);
    end
  end

  task automatic send(logic [1:0] o, logic cls, logic [5:0] pos, logic signed [11:0] val,
                      logic is_ac, logic [7:0] idx, logic [15:0] code, logic [4:0] len);
    @(negedge clk);
    op <= o;
    table_class <= cls;
    coeff_pos <= pos;
    coeff_value <= val;
    entry_is_ac <= is_ac;
    entry_index <= idx;
    entry_code <= code;
    entry_length <= len;
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    stream_sb.note_transfer(o, cls, pos, val, is_ac, idx, code, len);
    items_sent++;
    if (burst_left == 0) begin
      int gap;
      gap = $urandom_range(0, 6);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 0;
        repeat (gap - 1) @(negedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_load(logic is_ac, logic cls, logic [7:0] idx, logic [15:0] code,
                           logic [4:0] len);
    send(OP_LOAD, cls, 6'($urandom), 12'($urandom), is_ac, idx, code, len);
  endtask

  task automatic send_op(logic [1:0] o);
    send(o, 1'($urandom), 6'($urandom), 12'($urandom), 1'($urandom), 8'($urandom),
         16'($urandom), 5'($urandom));
  endtask

  // loads any table entry the coefficient would read before sending it
  task automatic send_coeff(logic cls, logic [5:0] pos, logic signed [11:0] val);
    int need[$];
    stream_sb.missing_entries(cls, pos, val, need);
    foreach (need[i])
      send_load(need[i] >= 256, cls, 8'(need[i] % 256), 16'($urandom),
                5'($urandom_range(1, 16)));
    send(OP_ENCODE, cls, pos, val, 1'($urandom), 8'($urandom), 16'($urandom),
         5'($urandom));
  endtask

  function automatic logic signed [11:0] rand_coeff();
    int c;
    int m;
    c = $urandom_range(1, 11);
    m = $urandom_range(1, (1 << c) - 1);
    return $urandom_range(0, 1) ? 12'(-m) : 12'(m);
  endfunction

  task automatic settle();
    while (stream_sb.expected_bytes.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(logic [31:0] lim);
    @(negedge clk);
    in_valid <= 0;
    settle();
    @(negedge clk);
    cfg_wr_en <= 1;
    cfg_wr_data <= lim;
    @(negedge clk);
    cfg_wr_en <= 0;
    stream_sb.byte_limit = lim;
  endtask

  task automatic random_phase(int target);
    int stop;
    int r;
    logic cls;
    stop = items_sent + target;
    while (items_sent < stop) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        cls = $urandom_range(0, 1);
        for (int p = 0; p < COEFFS_PER_BLOCK && items_sent < stop; p++) begin
          if ($urandom_range(0, 99) < 3)
            send_coeff(1'($urandom), 6'($urandom), 12'($urandom));
          if ($urandom_range(0, 63) < p + 10) send_coeff(cls, 6'(p), '0);
          else send_coeff(cls, 6'(p), rand_coeff());
        end
        if ($urandom_range(0, 2) == 0) send_op(OP_FLUSH);
      end else if (r < 82) begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 1))
            send_load(1, 1'($urandom), 8'($urandom), 16'($urandom), 5'($urandom));
          else
            send_load(0, 1'($urandom), 8'($urandom_range(0, 15)), 16'($urandom),
                      5'($urandom));
        end
      end else if (r < 90) begin
        send_coeff(1'($urandom), 6'($urandom), 12'($urandom));
      end else if (r < 96) begin
        send_op(OP_FLUSH);
      end else begin
        send_op(OP_RESTART);
      end
    end
  endtask

  initial begin
    #4000000;
    $display("jpeg_huffman_entropy_coder test failed");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: extremes, stuffing, saturation, eob, ignored loads, flush, restart
    send_load(1, 0, 8'h11, 16'hFFFF, 5'd16);
    send_load(0, 0, 8'd14, 16'h1234, 5'd5);
    send_load(0, 0, 8'd0, 16'hFFFF, 5'd31);
    send_coeff(0, 6'd0, 12'sd0);
    send_coeff(0, 6'd0, 12'sd2047);
    send_coeff(0, 6'd0, -12'sd2048);
    send_coeff(0, 6'd1, 12'sd1);
    send_coeff(0, 6'd2, -12'sd1);
    send_coeff(0, 6'd3, -12'sd2047);
    send_coeff(0, 6'd63, 12'sd0);
    send_coeff(0, 6'd63, 12'sd5);
    send_coeff(1, 6'd0, -12'sd1);
    send_coeff(1, 6'd40, 12'sd0);
    send_coeff(1, 6'd41, 12'sd3);
    send_op(OP_FLUSH);
    send_op(OP_FLUSH);
    send_coeff(1, 6'd7, 12'sd1);
    send_op(OP_RESTART);

    random_phase(ITEM_TARGET / 4);
    write_limit(32'd0);
    send_op(OP_RESTART);
    random_phase(ITEM_TARGET / 8);
    write_limit(32'd37);
    send_op(OP_RESTART);
    random_phase(ITEM_TARGET / 4);
    write_limit(32'd400);
    send_op(OP_RESTART);
    random_phase(ITEM_TARGET / 8);
    write_limit(32'hFFFF_FFFF);
    send_op(OP_RESTART);
    random_phase(ITEM_TARGET / 4);
    send_op(OP_FLUSH);

    @(negedge clk);
    in_valid <= 0;
    settle();
    if (stream_sb.expected_bytes.size() > 0)
      report($sformatf("%0d expected bytes never arrived", stream_sb.expected_bytes.size()));
    if (errors == 0) begin
      $display("jpeg_huffman_entropy_coder test passed");
    end else begin
      $display("jpeg_huffman_entropy_coder test failed");
    end
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+design
design/jhe_pkg.sv
design/jhe_ram.sv
design/jhe_packer.sv
design/jhe_seq.sv
design/jpeg_huffman_entropy_coder.sv
tb/sv/jpeg_huffman_entropy_coder_tb.sv
